### src/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and codes of the multi-channel timer table.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int unsigned IdW   = 32;
  localparam int unsigned TimeW = 48;
  localparam int unsigned MaxRes = 16;

  localparam logic [1:0] ACT_REG   = 2'd0;
  localparam logic [1:0] ACT_UNREG = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_UNREG = 2'd1;
  localparam logic [1:0] KIND_FIRE  = 2'd2;
  localparam logic [1:0] KIND_IDLE  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO_ID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOT_FND  = 3'd3;
  localparam logic [2:0] ST_ZERO_REP = 3'd4;

  localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

  typedef struct packed {
    logic start;     // begin a scan with a new request
    logic step;      // examine current slot
    logic emit_idle; // close a tick: held fire as last, or idle reply
    logic finish;    // register/unregister reply
  } mtt_cmd_t;

  typedef struct packed {
    logic scan_done; // last slot examined
    logic hit;       // current slot fires this cycle
    logic full16;    // next fire reaches the result limit
  } mtt_stat_t;

endpackage

### src/mtt_ctrl.sv
// ----------------------------------------------------------------------------
// mtt_ctrl
// Sequencer: accept one request, scan slots, drive result handshake.
// ----------------------------------------------------------------------------
module mtt_ctrl
  import mtt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] in_action,
  input  logic      out_busy,
  input  mtt_stat_t stat,
  output mtt_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT} state_t;
  state_t state_r, state_nxt;
  logic   tick_r, tick_nxt;

  assign in_ready = (state_r == S_IDLE) && !out_busy;

  always_comb begin
    state_nxt = state_r;
    tick_nxt  = tick_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready && (in_action != ACT_NONE)) begin
          cmd.start = 1'b1;
          tick_nxt  = (in_action == ACT_TICK);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!out_busy) begin
          cmd.step = 1'b1;
          if (stat.scan_done || (stat.hit && stat.full16)) begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (!out_busy) begin
          if (!tick_r) cmd.finish = 1'b1;
          else cmd.emit_idle = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
    end
  end

endmodule

### src/mtt_dp.sv
// ----------------------------------------------------------------------------
// mtt_dp
// Slot storage, time counter, scan pointer and output register.
// ----------------------------------------------------------------------------
module mtt_dp
  import mtt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mtt_cmd_t    cmd,
  output mtt_stat_t   stat,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_timer_id,
  input  logic [31:0] in_interval_ms,
  input  logic [31:0] in_repeat_count,
  output logic        out_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_status,
  output logic [31:0] out_fired_id,
  output logic [31:0] out_elapsed_ms,
  output logic        out_last
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(MaxRes + 1);

  logic [SLOTS-1:0] valid_r;
  logic [31:0]      id_m   [SLOTS];
  logic [31:0]      ivl_m  [SLOTS];
  logic [31:0]      rem_m  [SLOTS];
  logic [TimeW-1:0] lst_m  [SLOTS];
  logic [TimeW-1:0] nxt_m  [SLOTS];

  logic [TimeW-1:0] now_r;
  logic [SW-1:0]    ptr_r;
  logic [CW-1:0]    cnt_r;
  logic [1:0]       act_r;
  logic [31:0]      id_r, ivl_r, rep_r;
  logic             found_r, free_r;
  logic [SW-1:0]    fslot_r, eslot_r;

  logic        hv_r;
  logic [31:0] hid_r, hel_r;

  logic        ov_r;
  logic [1:0]  ok_r;
  logic [2:0]  os_r;
  logic [31:0] oid_r, oel_r;
  logic        ol_r;

  logic [31:0]      c_id, c_ivl, c_rem, rem_dec, el;
  logic [TimeW-1:0] c_lst, c_nxt, dt;
  logic             c_v, due, last_slot, wr_fire, ld_out;

  assign c_v   = valid_r[ptr_r];
  assign c_id  = id_m[ptr_r];
  assign c_ivl = ivl_m[ptr_r];
  assign c_rem = rem_m[ptr_r];
  assign c_lst = lst_m[ptr_r];
  assign c_nxt = nxt_m[ptr_r];
  assign due   = c_v && (c_nxt <= now_r) && (act_r == ACT_TICK);
  assign dt    = now_r - c_lst;
  assign el    = (dt[TimeW-1:32] != '0) ? FOREVER : dt[31:0];
  assign rem_dec = (c_rem == FOREVER) ? c_rem : c_rem - 32'd1;
  assign last_slot = (ptr_r == SW'(SLOTS - 1));

  assign stat.hit       = due;
  assign stat.scan_done = last_slot;
  assign stat.full16    = (cnt_r == CW'(MaxRes - 1));

  // hold each fire until the next one or the end of the tick decides tlast
  assign wr_fire = cmd.step && due;
  assign ld_out  = (wr_fire && hv_r) || cmd.emit_idle || cmd.finish;

  assign out_busy = ov_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      now_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (ld_out) ov_r <= 1'b1;
      else if (out_valid && out_ready) ov_r <= 1'b0;
      if (cmd.start && in_action == ACT_TICK) now_r <= now_r + TimeW'(1);
      if (wr_fire && rem_dec == 32'd0) valid_r[ptr_r] <= 1'b0;
      if (cmd.finish) begin
        if (act_r == ACT_REG && id_r != '0 && rep_r != '0 && (found_r || free_r))
          valid_r[found_r ? fslot_r : eslot_r] <= 1'b1;
        if (act_r == ACT_UNREG && id_r != '0 && found_r)
          valid_r[fslot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr_r   <= '0;
      cnt_r   <= '0;
      act_r   <= in_action;
      id_r    <= in_timer_id;
      ivl_r   <= in_interval_ms;
      rep_r   <= in_repeat_count;
      found_r <= 1'b0;
      free_r  <= 1'b0;
      hv_r    <= 1'b0;
    end
    if (cmd.step) begin
      if (!last_slot) ptr_r <= ptr_r + SW'(1);
      if (c_v && c_id == id_r && !found_r) begin
        found_r <= 1'b1;
        fslot_r <= ptr_r;
      end
      if (!c_v && !free_r) begin
        free_r  <= 1'b1;
        eslot_r <= ptr_r;
      end
    end
    if (wr_fire) begin
      cnt_r <= cnt_r + CW'(1);
      rem_m[ptr_r] <= rem_dec;
      lst_m[ptr_r] <= now_r;
      nxt_m[ptr_r] <= c_nxt + TimeW'(c_ivl);
      hv_r  <= 1'b1;
      hid_r <= c_id;
      hel_r <= el;
      if (hv_r) begin
        ok_r  <= KIND_FIRE;
        os_r  <= ST_OK;
        oid_r <= hid_r;
        oel_r <= hel_r;
        ol_r  <= 1'b0;
      end
    end
    if (cmd.emit_idle) begin
      ok_r  <= hv_r ? KIND_FIRE : KIND_IDLE;
      os_r  <= ST_OK;
      oid_r <= hv_r ? hid_r : '0;
      oel_r <= hv_r ? hel_r : '0;
      ol_r  <= 1'b1;
      hv_r  <= 1'b0;
    end
    if (cmd.finish) begin
      oid_r <= '0; oel_r <= '0; ol_r <= 1'b1;
      if (act_r == ACT_REG) begin
        ok_r <= KIND_REG;
        if (id_r == '0) os_r <= ST_ZERO_ID;
        else if (rep_r == '0) os_r <= ST_ZERO_REP;
        else if (!found_r && !free_r) os_r <= ST_FULL;
        else begin
          os_r <= ST_OK;
          id_m [found_r ? fslot_r : eslot_r] <= id_r;
          ivl_m[found_r ? fslot_r : eslot_r] <= ivl_r;
          rem_m[found_r ? fslot_r : eslot_r] <= rep_r;
          lst_m[found_r ? fslot_r : eslot_r] <= now_r;
          nxt_m[found_r ? fslot_r : eslot_r] <= now_r + TimeW'(ivl_r);
        end
      end else begin
        ok_r <= KIND_UNREG;
        if (id_r == '0) os_r <= ST_ZERO_ID;
        else if (!found_r) os_r <= ST_NOT_FND;
        else os_r <= ST_OK;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_kind       = ok_r;
  assign out_status     = os_r;
  assign out_fired_id   = oid_r;
  assign out_elapsed_ms = oel_r;
  assign out_last       = ol_r;

endmodule

### src/multi_timer_table.sv
// Result: the final result is registered from S_WAIT after the scan, sooner when
// a tick reaches the result limit early; output stalls add to this.
// Throughput: no new request until the previous reply is loaded; one slot per cycle when unstalled.
// A fire is held until the next is found or the tick ends; a full output stalls it.
// Reset: synchronous active-low; clears slot valid bits, time and control.
// ----------------------------------------------------------------------------
// multi_timer_table
// Table of periodic timers with register, unregister and tick requests.
// ----------------------------------------------------------------------------
module multi_timer_table
  import mtt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // action[1:0] timer_id interval_ms repeat_count, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata, // kind[1:0] status[4:2] fired_id elapsed_ms, pad
  output logic         out_tlast
);

  mtt_cmd_t  cmd;
  mtt_stat_t stat;
  logic      busy;

  mtt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_action(in_tdata[1:0]), .out_busy(busy), .stat, .cmd
  );

  mtt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_action(in_tdata[1:0]), .in_timer_id(in_tdata[33:2]),
    .in_interval_ms(in_tdata[65:34]), .in_repeat_count(in_tdata[97:66]),
    .out_busy(busy), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_kind(out_tdata[1:0]), .out_status(out_tdata[4:2]),
    .out_fired_id(out_tdata[36:5]), .out_elapsed_ms(out_tdata[68:37]),
    .out_last(out_tlast)
  );

  assign out_tdata[71:69] = '0;

endmodule

### src/mtt_checker.sv
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level checks of the timer table.
// ----------------------------------------------------------------------------
module mtt_checker
  import mtt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_action,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_nonfire_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != KIND_FIRE |-> out_tlast)
    else $error("reply not marked last");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_FIRE |-> out_tdata[4:2] == ST_OK)
    else $error("fired result with status");

  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_action != ACT_NONE |=> !in_tready)
    else $error("accepted while busy");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_action(in_tdata[1:0]),
  .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives register, unregister and tick requests into the timer table, predicts
// every reply and firing, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module testbench
  import mtt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam logic [47:0] T48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] fired_id;
    logic [31:0] elapsed_ms;
    logic        last;
  } timer_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic         out_tlast;

  multi_timer_table #(.SLOTS(NSLOT)) DUT (.*);

  always #6 clk = ~clk;

  logic        tv_valid[NSLOT];
  logic [31:0] tv_id[NSLOT];
  logic [31:0] tv_interval[NSLOT];
  logic [31:0] tv_remaining[NSLOT];
  logic [47:0] tv_last[NSLOT];
  logic [47:0] tv_next[NSLOT];
  logic [47:0] clock_ms;

  timer_result_t pending_results[$];
  int  errors = 0;
  bit  stall_en = 1'b1;
  bit  hold_off = 1'b0;
  bit  gap_en = 1'b1;

  function automatic int find_timer(logic [31:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (tv_valid[i] && tv_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [2:0] st, logic [31:0] id,
                                      logic [31:0] el, logic lst);
    timer_result_t r;
    r.kind = k; r.status = st; r.fired_id = id; r.elapsed_ms = el; r.last = lst;
    pending_results = {pending_results, r};
  endfunction

  function automatic void predict_timers(logic [1:0] act, logic [31:0] id,
                                         logic [31:0] ival, logic [31:0] reps);
    int s;
    int n;
    logic [47:0] dt;
    logic [31:0] el;
    timer_result_t fires[$];
    timer_result_t r;
    case (act)
      ACT_REG: begin
        if (id == 0) push_result(KIND_REG, ST_ZERO_ID, 0, 0, 1);
        else if (reps == 0) push_result(KIND_REG, ST_ZERO_REP, 0, 0, 1);
        else begin
          s = find_timer(id);
          if (s < 0)
            for (int i = NSLOT - 1; i >= 0; i--) if (!tv_valid[i]) s = i;
          if (s < 0) push_result(KIND_REG, ST_FULL, 0, 0, 1);
          else begin
            tv_valid[s] = 1; tv_id[s] = id; tv_interval[s] = ival;
            tv_remaining[s] = reps; tv_last[s] = clock_ms;
            tv_next[s] = (clock_ms + 48'(ival)) & T48;
            push_result(KIND_REG, ST_OK, 0, 0, 1);
          end
        end
      end
      ACT_UNREG: begin
        if (id == 0) push_result(KIND_UNREG, ST_ZERO_ID, 0, 0, 1);
        else begin
          s = find_timer(id);
          if (s < 0) push_result(KIND_UNREG, ST_NOT_FND, 0, 0, 1);
          else begin
            tv_valid[s] = 0;
            push_result(KIND_UNREG, ST_OK, 0, 0, 1);
          end
        end
      end
      ACT_TICK: begin
        clock_ms = clock_ms + 48'd1;
        n = 0;
        for (int i = 0; i < NSLOT && n < MaxRes; i++) begin
          if (tv_valid[i] && tv_next[i] <= clock_ms) begin
            dt = clock_ms - tv_last[i];
            el = (dt > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : dt[31:0];
            r.kind = KIND_FIRE; r.status = ST_OK; r.fired_id = tv_id[i];
            r.elapsed_ms = el; r.last = 0;
            fires = {fires, r};
            n++;
            if (tv_remaining[i] != FOREVER) tv_remaining[i]--;
            if (tv_remaining[i] != 0) begin
              tv_last[i] = clock_ms;
              tv_next[i] = tv_next[i] + 48'(tv_interval[i]);
            end else tv_valid[i] = 0;
          end
        end
        if (n == 0) push_result(KIND_IDLE, ST_OK, 0, 0, 1);
        else begin
          fires[n - 1].last = 1;
          pending_results = {pending_results, fires};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [1:0] act, logic [31:0] id, logic [31:0] ival,
                              logic [31:0] reps);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tdata <= {6'd0, reps, ival, id, act};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_timers(act, id, ival, reps);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (stall_en && $urandom_range(0, 7) == 0) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    timer_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[4:2], out_tdata[36:5], out_tdata[68:37], out_tlast};
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d", got.kind);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind) begin
          $error("kind exp %0d got %0d", want.kind, got.kind); errors++;
        end
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.fired_id != want.fired_id) begin
          $error("fired_id exp %h got %h", want.fired_id, got.fired_id); errors++;
        end
        if (got.elapsed_ms != want.elapsed_ms) begin
          $error("elapsed_ms exp %h got %h", want.elapsed_ms, got.elapsed_ms); errors++;
        end
        if (got.last != want.last) begin
          $error("last exp %0d got %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_id();
    return (32'($urandom_range(1, 24)) ^ ($urandom_range(0, 7) == 0 ? $urandom : 0));
  endfunction

  task automatic test_special_cases();
    send_request(ACT_REG, 0, 5, 1);
    send_request(ACT_UNREG, 0, 0, 0);
    send_request(ACT_REG, 7, 5, 0);
    send_request(ACT_UNREG, 32'hFFFF_FFFF, 0, 0);
    send_request(ACT_TICK, 0, 0, 0);
    send_request(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_REG, 32'hFFFF_FFFF, 0, 2);
    send_request(ACT_REG, 32'h8000_0001, 1, FOREVER);
    send_request(ACT_REG, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_request(ACT_REG, 32'h8000_0001, 2, FOREVER);
    send_request(ACT_TICK, 0, 0, 0);
    send_request(ACT_TICK, 0, 0, 0);
    send_request(ACT_TICK, 0, 0, 0);
    send_request(ACT_UNREG, 32'h8000_0001, 0, 0);
    send_request(ACT_UNREG, 32'h8000_0001, 0, 0);
    drain_results();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NSLOT + 2; i++) send_request(ACT_REG, 100 + i, 1, 1);
    send_request(ACT_REG, 105, 1, 2);
    send_request(ACT_TICK, 0, 0, 0);
    send_request(ACT_TICK, 0, 0, 0);
    send_request(ACT_TICK, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < NSLOT; i++) send_request(ACT_REG, 200 + i, 1, 3);
        repeat (4) send_request(ACT_TICK, 0, 0, 0);
      end
    join
    drain_results();
  endtask

  task automatic test_random_mix(int count);
    logic [31:0] ival, reps;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      ival = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, 6));
      reps = ($urandom_range(0, 9) == 0) ? FOREVER :
             ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 5));
      if (r < 35) send_request(ACT_REG, pick_id(), ival, reps);
      else if (r < 48) send_request(ACT_UNREG, pick_id(), $urandom, $urandom);
      else if (r < 97) send_request(ACT_TICK, $urandom, $urandom, $urandom);
      else send_request(ACT_NONE, $urandom, $urandom, $urandom);
    end
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) tv_valid[i] = 0;
    clock_ms = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_full_table();
    test_backpressure();
    test_random_mix(350);
    stall_en = 1'b0;
    gap_en = 1'b0;
    test_random_mix(60);
    if (errors == 0 && pending_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
